FILE: src/stt_pkg.sv
// shared types and constants of the source text tokenizer
package stt_pkg;

  // defaults for the top level parameters
  localparam int MAX_VALUE_LEN_DEF = 32;
  localparam int POSITION_BITS_DEF = 24;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 4;
  localparam int POS_W      = 24;
  localparam int LEN_W      = 6;
  localparam int IDX_OUT_W  = 5;
  localparam int OUT_DATA_W = 48;

  // command queue depth between front and back
  localparam int FIFO_DEPTH = 4;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_STRING  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CHAR    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LBRACK  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RBRACK  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd10;

  // token produced by the front, carried out by the back
  typedef struct packed {
    logic                  is_value;
    logic [KIND_W-1:0]     kind;
    logic [POS_W-1:0]      pos;
    logic [BYTE_W-1:0]     vbyte;
    logic [LEN_W-1:0]      count;
    logic                  bank;
    logic                  trunc;
    logic                  last;
  } stt_cmd_t;

  // value store write port
  typedef struct packed {
    logic                  en;
    logic                  bank;
    logic [LEN_W-1:0]      addr;
    logic [BYTE_W-1:0]     data;
  } stt_wr_t;

endpackage

FILE: src/stt_cmd_fifo.sv
// short token command queue between the front and the back
module stt_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stt_pkg::stt_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output stt_pkg::stt_cmd_t pop_cmd,
  output logic              empty
);
  import stt_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  stt_cmd_t         slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slot_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/stt_front.sv
// lexer front: accepts text bytes, tracks mode, fills the value store, queues tokens
module stt_front #(
  parameter int MAX_VALUE_LEN = stt_pkg::MAX_VALUE_LEN_DEF,
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [stt_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_sot,
  output logic                       push,
  output stt_pkg::stt_cmd_t          push_cmd,
  input  logic                       fifo_full,
  input  logic                       value_done,
  output stt_pkg::stt_wr_t           wr
);
  import stt_pkg::*;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_STRING = 5'b00010,
    MODE_CHAR   = 5'b00100,
    MODE_NUMBER = 5'b01000,
    MODE_SYMBOL = 5'b10000
  } lex_mode_t;

  localparam logic [LEN_W-1:0]         MAX_LEN = LEN_W'(MAX_VALUE_LEN);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  lex_mode_t              mode_r, mode_nxt, mode_e;
  logic [LEN_W-1:0]       cnt_r, cnt_nxt, cnt_e, cnt_b;
  logic                   ovf_r, ovf_nxt, ovf_e, ovf_b;
  logic                   bank_r, bank_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_e;
  logic                   busy_r, busy_nxt;
  logic                   pend_r, pend_nxt;
  stt_cmd_t               pend_cmd_r, pend_cmd_nxt;
  logic [POS_W-1:0]       pos24;
  logic                   acc;
  logic                   emit_val, idle_pass, single, do_begin, do_append;
  logic [KIND_W-1:0]      val_kind, single_kind;
  stt_cmd_t               val_cmd, sgl_cmd;

  assign in_ready = !pend_r && !busy_r && !fifo_full;
  assign acc      = in_valid && in_ready;

  // start of text restarts the lexer before this byte
  assign mode_e = in_sot ? MODE_IDLE : mode_r;
  assign cnt_e  = in_sot ? '0 : cnt_r;
  assign ovf_e  = in_sot ? 1'b0 : ovf_r;
  assign pos_e  = in_sot ? '0 : pos_r;

  // reported position saturates at the field width
  if (POSITION_BITS > POS_W) begin : g_pos_sat
    assign pos24 = (|pos_e[POSITION_BITS-1:POS_W]) ? {POS_W{1'b1}} : pos_e[POS_W-1:0];
  end else begin : g_pos_ext
    assign pos24 = POS_W'(pos_e);
  end

  // byte classification against the current mode
  always_comb begin
    mode_nxt    = mode_e;
    emit_val    = 1'b0;
    val_kind    = KIND_SYMBOL;
    idle_pass   = 1'b0;
    single      = 1'b0;
    single_kind = KIND_UNKNOWN;
    do_begin    = 1'b0;
    do_append   = 1'b0;
    case (mode_e)
      MODE_STRING: begin
        if (in_byte == CH_DQUOTE) begin
          emit_val = 1'b1;
          val_kind = KIND_STRING;
          mode_nxt = MODE_IDLE;
        end else begin
          do_append = 1'b1;
        end
      end
      MODE_CHAR: begin
        if (in_byte == CH_SQUOTE) begin
          emit_val = 1'b1;
          val_kind = KIND_CHAR;
          mode_nxt = MODE_IDLE;
        end else begin
          do_append = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(in_byte)) begin
          do_append = 1'b1;
        end else begin
          emit_val  = 1'b1;
          val_kind  = KIND_NUMBER;
          mode_nxt  = MODE_IDLE;
          idle_pass = 1'b1;
        end
      end
      MODE_SYMBOL: begin
        if (is_alpha(in_byte) || is_digit(in_byte)) begin
          do_append = 1'b1;
        end else begin
          emit_val  = 1'b1;
          val_kind  = KIND_SYMBOL;
          mode_nxt  = MODE_IDLE;
          idle_pass = 1'b1;
        end
      end
      default: begin
        mode_nxt  = MODE_IDLE;
        idle_pass = 1'b1;
      end
    endcase
    // the byte handled as if idle
    if (idle_pass) begin
      if (is_alpha(in_byte)) begin
        mode_nxt  = MODE_SYMBOL;
        do_begin  = 1'b1;
        do_append = 1'b1;
      end else if (is_digit(in_byte)) begin
        mode_nxt  = MODE_NUMBER;
        do_begin  = 1'b1;
        do_append = 1'b1;
      end else if (is_space(in_byte)) begin
        mode_nxt = MODE_IDLE;
      end else if (in_byte == CH_DQUOTE) begin
        mode_nxt = MODE_STRING;
        do_begin = 1'b1;
      end else if (in_byte == CH_SQUOTE) begin
        mode_nxt = MODE_CHAR;
        do_begin = 1'b1;
      end else begin
        single = 1'b1;
        case (in_byte)
          CH_LPAREN: single_kind = KIND_LPAREN;
          CH_RPAREN: single_kind = KIND_RPAREN;
          CH_LBRACK: single_kind = KIND_LBRACK;
          CH_RBRACK: single_kind = KIND_RBRACK;
          CH_LBRACE: single_kind = KIND_LBRACE;
          CH_RBRACE: single_kind = KIND_RBRACE;
          default:   single_kind = KIND_UNKNOWN;
        endcase
      end
    end
  end

  // value buffer update; a new value goes to the other bank
  always_comb begin
    cnt_b    = do_begin ? '0 : cnt_e;
    ovf_b    = do_begin ? 1'b0 : ovf_e;
    bank_nxt = do_begin ? ~bank_r : bank_r;
    cnt_nxt  = cnt_b;
    ovf_nxt  = ovf_b;
    wr.en    = 1'b0;
    wr.bank  = bank_nxt;
    wr.addr  = cnt_b;
    wr.data  = in_byte;
    if (do_append) begin
      if (cnt_b < MAX_LEN) begin
        wr.en   = acc;
        cnt_nxt = cnt_b + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    pos_nxt = (pos_e == POS_MAX) ? pos_e : pos_e + POSITION_BITS'(1);
  end

  // token commands
  always_comb begin
    val_cmd.is_value = 1'b1;
    val_cmd.kind     = val_kind;
    val_cmd.pos      = pos24;
    val_cmd.vbyte    = '0;
    val_cmd.count    = cnt_e;
    val_cmd.bank     = bank_r;
    val_cmd.trunc    = ovf_e;
    val_cmd.last     = !single;
    sgl_cmd.is_value = 1'b0;
    sgl_cmd.kind     = single_kind;
    sgl_cmd.pos      = pos24;
    sgl_cmd.vbyte    = in_byte;
    sgl_cmd.count    = LEN_W'(1);
    sgl_cmd.bank     = 1'b0;
    sgl_cmd.trunc    = 1'b0;
    sgl_cmd.last     = 1'b1;
  end

  // queue write; a second token of the same byte is held and pushed once the queue has room
  always_comb begin
    push         = 1'b0;
    push_cmd     = sgl_cmd;
    pend_nxt     = pend_r;
    pend_cmd_nxt = pend_cmd_r;
    busy_nxt     = busy_r;
    if (pend_r) begin
      push     = !fifo_full;
      push_cmd = pend_cmd_r;
      if (!fifo_full) begin
        pend_nxt = 1'b0;
      end
    end else if (acc) begin
      push     = emit_val || single;
      push_cmd = emit_val ? val_cmd : sgl_cmd;
      if (emit_val && single) begin
        pend_nxt     = 1'b1;
        pend_cmd_nxt = sgl_cmd;
      end
    end
    // value drain in progress holds off the input
    if (acc && emit_val) begin
      busy_nxt = 1'b1;
    end else if (value_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
      pos_r  <= '0;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        ovf_r  <= ovf_nxt;
        bank_r <= bank_nxt;
        pos_r  <= pos_nxt;
      end
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_cmd_r <= pend_cmd_nxt;
  end

`ifndef SYNTH
  // stored length never passes the buffer size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_LEN)
    else $error("value count beyond buffer size");

  // dropped bytes only happen with a full buffer
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == MAX_LEN))
    else $error("overflow flag with buffer not full");

  // a held second token comes only from a byte taken the cycle before
  a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !$past(pend_r)) |-> $past(in_valid && in_ready))
    else $error("pending token without an accepted byte");
`endif

endmodule

FILE: src/stt_back.sv
// token back end: value store, byte-by-byte drain and output register
module stt_back #(
  parameter int MAX_VALUE_LEN = stt_pkg::MAX_VALUE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fifo_empty,
  input  stt_pkg::stt_cmd_t              fifo_cmd,
  output logic                           fifo_pop,
  input  stt_pkg::stt_wr_t               wr,
  output logic                           value_done,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stt_pkg::OUT_DATA_W-1:0] out_data,
  output logic [stt_pkg::KIND_W-1:0]     out_kind,
  output logic                           out_last
);
  import stt_pkg::*;

  localparam int IDX_W = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SHOW = 3'b100
  } back_state_t;

  logic [BYTE_W-1:0]    value_mem [2][MAX_VALUE_LEN];
  logic [BYTE_W-1:0]    rd_data_r;
  back_state_t          state_r, state_nxt;
  stt_cmd_t             cur_r, cur_nxt;
  logic [LEN_W-1:0]     idx_r, idx_nxt, idx_inc, rd_idx;
  logic                 rd_en, rd_bank;
  logic                 out_valid_r, out_valid_nxt, load_cmd, load_mem;
  logic [KIND_W-1:0]    o_kind_r, o_kind_nxt;
  logic [POS_W-1:0]     o_pos_r, o_pos_nxt;
  logic [BYTE_W-1:0]    o_vb_r, o_vb_nxt;
  logic                 o_bv_r, o_bv_nxt;
  logic [IDX_OUT_W-1:0] o_idx_r, o_idx_nxt;
  logic [LEN_W-1:0]     o_len_r, o_len_nxt;
  logic                 o_trunc_r, o_trunc_nxt;
  logic                 o_lot_r, o_lot_nxt;
  logic                 o_last_r, o_last_nxt;

  assign idx_inc = idx_r + LEN_W'(1);

  // drain sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    fifo_pop      = 1'b0;
    rd_en         = 1'b0;
    rd_bank       = cur_r.bank;
    rd_idx        = idx_inc;
    value_done    = 1'b0;
    out_valid_nxt = out_valid_r;
    load_cmd      = 1'b0;
    load_mem      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop = 1'b1;
          cur_nxt  = fifo_cmd;
          idx_nxt  = '0;
          if (fifo_cmd.is_value && (fifo_cmd.count != '0)) begin
            rd_en     = 1'b1;
            rd_bank   = fifo_cmd.bank;
            rd_idx    = '0;
            state_nxt = BK_READ;
          end else begin
            load_cmd      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = BK_SHOW;
          end
        end
      end
      BK_READ: begin
        load_mem      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (cur_r.is_value && (idx_inc < cur_r.count)) begin
            idx_nxt   = idx_inc;
            rd_en     = 1'b1;
            state_nxt = BK_READ;
          end else begin
            value_done = cur_r.is_value;
            state_nxt  = BK_IDLE;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = BK_IDLE;
      end
    endcase
  end

  // output register contents
  always_comb begin
    o_kind_nxt  = o_kind_r;
    o_pos_nxt   = o_pos_r;
    o_vb_nxt    = o_vb_r;
    o_bv_nxt    = o_bv_r;
    o_idx_nxt   = o_idx_r;
    o_len_nxt   = o_len_r;
    o_trunc_nxt = o_trunc_r;
    o_lot_nxt   = o_lot_r;
    o_last_nxt  = o_last_r;
    if (load_cmd) begin
      // bracket, unknown byte or empty value
      o_kind_nxt  = fifo_cmd.kind;
      o_pos_nxt   = fifo_cmd.pos;
      o_vb_nxt    = fifo_cmd.is_value ? '0 : fifo_cmd.vbyte;
      o_bv_nxt    = !fifo_cmd.is_value;
      o_idx_nxt   = '0;
      o_len_nxt   = fifo_cmd.is_value ? '0 : fifo_cmd.count;
      o_trunc_nxt = fifo_cmd.trunc;
      o_lot_nxt   = 1'b1;
      o_last_nxt  = fifo_cmd.last;
    end else if (load_mem) begin
      // one stored value byte
      o_kind_nxt  = cur_r.kind;
      o_pos_nxt   = cur_r.pos;
      o_vb_nxt    = rd_data_r;
      o_bv_nxt    = 1'b1;
      o_idx_nxt   = idx_r[IDX_OUT_W-1:0];
      o_len_nxt   = cur_r.count;
      o_trunc_nxt = cur_r.trunc;
      o_lot_nxt   = (idx_inc == cur_r.count);
      o_last_nxt  = cur_r.last && (idx_inc == cur_r.count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    idx_r     <= idx_nxt;
    o_kind_r  <= o_kind_nxt;
    o_pos_r   <= o_pos_nxt;
    o_vb_r    <= o_vb_nxt;
    o_bv_r    <= o_bv_nxt;
    o_idx_r   <= o_idx_nxt;
    o_len_r   <= o_len_nxt;
    o_trunc_r <= o_trunc_nxt;
    o_lot_r   <= o_lot_nxt;
    o_last_r  <= o_last_nxt;
  end

  // two-bank value store, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      value_mem[wr.bank][wr.addr[IDX_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= value_mem[rd_bank][rd_idx[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = o_kind_r;
  assign out_last  = o_last_r;
  assign out_data  = {2'b00, o_lot_r, o_trunc_r, o_len_r, o_idx_r, o_bv_r, o_vb_r, o_pos_r};

endmodule

FILE: src/source_text_tokenizer_unit.sv
// top level of the source text tokenizer
// Source text enters one byte per item and leaves as token items, one per stored
// value byte (or one item for an empty value, a bracket or an unknown byte). A byte
// that extends a token, opens one or is whitespace does not itself hold the input.
// A byte that completes a string, char, number or symbol token holds the input
// until that token has left: the token enters the queue, the back end picks it up
// and then, for each value byte, reads the value store and loads the output
// register, and waits whenever the output stalls. A bracket or unknown byte token
// needs no value store read in the back end; a short queue lets the front keep
// taking bytes meanwhile. There is no clearing pass after reset.
module source_text_tokenizer_unit #(
  parameter int MAX_VALUE_LEN = stt_pkg::MAX_VALUE_LEN_DEF,
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // text_byte
  input  logic [stt_pkg::BYTE_W-1:0]     in_tdata,
  // start_of_text
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // token_position, value_byte, byte_valid, byte_index, value_length,
  // truncated, last_of_token, zero pad
  output logic [stt_pkg::OUT_DATA_W-1:0] out_tdata,
  // token_kind
  output logic [stt_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);
  import stt_pkg::*;

  stt_cmd_t push_cmd, pop_cmd;
  stt_wr_t  wr;
  logic     push, pop, fifo_full, fifo_empty, value_done;

  // front: classification and value capture
  stt_front #(
    .MAX_VALUE_LEN (MAX_VALUE_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_sot     (in_tuser),
    .push       (push),
    .push_cmd   (push_cmd),
    .fifo_full  (fifo_full),
    .value_done (value_done),
    .wr         (wr)
  );

  // token queue
  stt_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  // back: value drain and output
  stt_back #(
    .MAX_VALUE_LEN (MAX_VALUE_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_cmd   (pop_cmd),
    .fifo_pop   (pop),
    .wr         (wr),
    .value_done (value_done),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

FILE: test/tb.sv
// testbench for the source text tokenizer: directed and random text checked against a token predictor
`timescale 1ns / 100ps

module tb;
  import stt_pkg::*;

  // lexer modes of the predictor
  typedef enum int {LEX_IDLE, LEX_STRING, LEX_CHAR, LEX_NUMBER, LEX_SYMBOL} lex_mode_t;

  // one expected token item, fields as they leave the block
  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     pos;
    logic [BYTE_W-1:0]    vbyte;
    logic                 valid;
    logic [IDX_OUT_W-1:0] idx;
    logic [LEN_W-1:0]     len;
    logic                 trunc;
    logic                 lot;
    logic                 last;
  } token_item_t;

  // special characters
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int VALUE_MAX   = MAX_VALUE_LEN_DEF;
  localparam int TEXT_ITEMS  = 480;
  localparam int STUCK_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 60;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  // predictor state
  lex_mode_t         lex_mode = LEX_IDLE;
  logic [7:0]        val_buf [VALUE_MAX];
  int                val_len = 0;
  logic              val_trunc = 1'b0;
  logic [POS_W-1:0]  txt_pos = '0;
  int                emitted;
  token_item_t       token_q[$];

  int  errors = 0;
  int  sent_items = 0;
  bit  idle_on = 1'b1;
  int  rx_wait = 0;
  int  rx_draw;
  int  stuck_cycles = 0;

  source_text_tokenizer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // idle cycles before an item, on either side
  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 8)) : 0;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic report(input string msg);
    if (errors < 40) $display("tb: mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // predictor helpers
  task automatic push_token(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [7:0] vbyte, input logic valid, input int idx,
                            input int len, input logic trunc, input logic lot);
    token_item_t t;
    t.kind  = kind;
    t.pos   = pos;
    t.vbyte = vbyte;
    t.valid = valid;
    t.idx   = idx[IDX_OUT_W-1:0];
    t.len   = len[LEN_W-1:0];
    t.trunc = trunc;
    t.lot   = lot;
    t.last  = 1'b0;
    token_q.insert(token_q.size(), t);
    emitted++;
  endtask

  task automatic push_value(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos);
    if (val_len == 0) begin
      push_token(kind, pos, 8'h00, 1'b0, 0, 0, val_trunc, 1'b1);
    end else begin
      for (int i = 0; i < val_len; i++)
        push_token(kind, pos, val_buf[i], 1'b1, i, val_len, val_trunc, i == val_len - 1);
    end
  endtask

  task automatic store_byte(input logic [7:0] c);
    if (val_len < VALUE_MAX) begin
      val_buf[val_len] = c;
      val_len++;
    end else begin
      val_trunc = 1'b1;
    end
  endtask

  task automatic open_value(input lex_mode_t mode);
    lex_mode  = mode;
    val_len   = 0;
    val_trunc = 1'b0;
  endtask

  // expected token items caused by one accepted text byte
  task automatic tokenize_byte(input logic [7:0] c, input logic sot);
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
    bit                rescan;
    token_item_t       tail;
    emitted = 0;
    if (sot) begin
      lex_mode  = LEX_IDLE;
      txt_pos   = '0;
      val_len   = 0;
      val_trunc = 1'b0;
    end
    pos    = txt_pos;
    rescan = (lex_mode == LEX_IDLE);
    case (lex_mode)
      LEX_STRING: begin
        if (c == CH_DQUOTE) begin
          push_value(KIND_STRING, pos);
          lex_mode = LEX_IDLE;
        end else store_byte(c);
      end
      LEX_CHAR: begin
        if (c == CH_SQUOTE) begin
          push_value(KIND_CHAR, pos);
          lex_mode = LEX_IDLE;
        end else store_byte(c);
      end
      LEX_NUMBER: begin
        if (is_digit(c)) store_byte(c);
        else begin
          push_value(KIND_NUMBER, pos);
          lex_mode = LEX_IDLE;
          rescan   = 1'b1;
        end
      end
      LEX_SYMBOL: begin
        if (is_alpha(c) || is_digit(c)) store_byte(c);
        else begin
          push_value(KIND_SYMBOL, pos);
          lex_mode = LEX_IDLE;
          rescan   = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase
    // a byte seen in idle mode, also the byte that ended a number or symbol
    if (rescan) begin
      if (is_alpha(c)) begin
        open_value(LEX_SYMBOL);
        store_byte(c);
      end else if (is_digit(c)) begin
        open_value(LEX_NUMBER);
        store_byte(c);
      end else if (is_space(c)) begin
        // whitespace emits nothing
      end else if (c == CH_DQUOTE) begin
        open_value(LEX_STRING);
      end else if (c == CH_SQUOTE) begin
        open_value(LEX_CHAR);
      end else begin
        case (c)
          CH_LPAREN: kind = KIND_LPAREN;
          CH_RPAREN: kind = KIND_RPAREN;
          CH_LBRACK: kind = KIND_LBRACK;
          CH_RBRACK: kind = KIND_RBRACK;
          CH_LBRACE: kind = KIND_LBRACE;
          CH_RBRACE: kind = KIND_RBRACE;
          default:   kind = KIND_UNKNOWN;
        endcase
        push_token(kind, pos, c, 1'b1, 0, 1, 1'b0, 1'b1);
      end
    end
    if (txt_pos != '1) txt_pos++;
    // mark the final item caused by this byte
    if (emitted > 0) begin
      tail = token_q.pop_back();
      tail.last = 1'b1;
      token_q.insert(token_q.size(), tail);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // compare one accepted token item with the oldest expectation
  task automatic check_token();
    token_item_t want;
    if (token_q.size() == 0) begin
      report($sformatf("unexpected item kind %0d data %0h", out_tuser, out_tdata));
      return;
    end
    want = token_q.pop_front();
    check_field("token_kind",     out_tuser,       want.kind);
    check_field("token_position", out_tdata[23:0], want.pos);
    check_field("value_byte",     out_tdata[31:24], want.vbyte);
    check_field("byte_valid",     out_tdata[32],    want.valid);
    check_field("byte_index",     out_tdata[37:33], want.idx);
    check_field("value_length",   out_tdata[43:38], want.len);
    check_field("truncated",      out_tdata[44],    want.trunc);
    check_field("last_of_token",  out_tdata[45],    want.lot);
    check_field("pad",            out_tdata[47:46], 2'b00);
    check_field("last",           out_tlast,        want.last);
  endtask

  // token receiver with random stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_token();
      rx_draw = draw_gap();
      rx_wait <= rx_draw;
      out_tready <= (rx_draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // send one text byte, called right after a rising edge
  task automatic send_item(input logic [7:0] b, input logic sot);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokenize_byte(b, sot);
    sent_items++;
  endtask

  // hold the input until every expected item has come
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  // random byte pickers
  function automatic logic [7:0] rand_alpha();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(9 + k);
  endfunction

  function automatic logic [7:0] rand_bracket();
    case ($urandom_range(0, 5))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] q);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == q);
    return b;
  endfunction

  // byte that ends a number or symbol
  function automatic logic [7:0] rand_terminator();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = rand_space();
      1: b = rand_bracket();
      2: do b = 8'($urandom_range(0, 255)); while (is_alpha(b) || is_digit(b));
      default: b = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    endcase
    return b;
  endfunction

  function automatic int rand_value_len();
    return ($urandom_range(0, 19) == 0) ? int'($urandom_range(28, 40))
                                        : int'($urandom_range(0, 6));
  endfunction

  task automatic send_symbol(input int n);
    send_item(rand_alpha(), 1'b0);
    for (int i = 0; i < n; i++)
      send_item($urandom_range(0, 1) ? rand_alpha() : rand_digit(), 1'b0);
    send_item(rand_terminator(), 1'b0);
  endtask

  task automatic send_number(input int n);
    for (int i = 0; i <= n; i++) send_item(rand_digit(), 1'b0);
    send_item(rand_terminator(), 1'b0);
  endtask

  task automatic send_literal(input logic [7:0] q, input int n, input bit closed);
    send_item(q, 1'b0);
    for (int i = 0; i < n; i++) send_item(rand_byte_except(q), 1'b0);
    if (closed) send_item(q, 1'b0);
  endtask

  // symbols, numbers and a byte that ends one token and makes another
  task automatic test_symbols_numbers();
    send_item("a", 1'b1);
    send_item("Z", 1'b0);
    send_item("9", 1'b0);
    send_item(CH_LPAREN, 1'b0);
    send_item("0", 1'b0);
    send_item("5", 1'b0);
    send_item(CH_RPAREN, 1'b0);
  endtask

  // brackets, unknown bytes at the byte extremes, whitespace
  task automatic test_brackets_unknown();
    send_item(CH_LBRACK, 1'b0);
    send_item(CH_RBRACK, 1'b0);
    send_item(CH_LBRACE, 1'b0);
    send_item(CH_RBRACE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h09, 1'b0);
    send_item(8'h0D, 1'b0);
    send_item(CH_SPACE, 1'b0);
  endtask

  // empty literals, a high byte inside a literal, closing quote not reopening
  task automatic test_literals();
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item("k", 1'b0);
  endtask

  // restart drops a pending token and zeroes the position
  task automatic test_restart();
    send_item("7", 1'b1);
    send_item(CH_DQUOTE, 1'b0);
    send_item("x", 1'b0);
    send_item("q", 1'b1);
    send_item(CH_SPACE, 1'b0);
  endtask

  // values at and past the buffer size
  task automatic test_long_values();
    send_literal(CH_DQUOTE, VALUE_MAX + 4, 1'b1);
    send_literal(CH_SQUOTE, VALUE_MAX, 1'b1);
    send_symbol(VALUE_MAX + 1);
    send_number(VALUE_MAX);
  endtask

  // mostly well formed random text, with noise, restarts and broken literals
  task automatic test_random_text();
    bit paused;
    int pick;
    paused = 1'b0;
    while (sent_items < TEXT_ITEMS) begin
      if (sent_items % 40 < 3) idle_on = ($urandom_range(0, 3) != 0);
      if (!paused && sent_items >= TEXT_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20)      send_symbol(rand_value_len());
      else if (pick < 34) send_number(rand_value_len());
      else if (pick < 49) send_literal(CH_DQUOTE, rand_value_len(), 1'b1);
      else if (pick < 58) send_literal(CH_SQUOTE, rand_value_len(), 1'b1);
      else if (pick < 72) send_item(rand_bracket(), 1'b0);
      else if (pick < 78) send_item(rand_space(), 1'b0);
      else if (pick < 91) send_item(8'($urandom_range(0, 255)), 1'b0);
      else if (pick < 95) send_item(8'($urandom_range(0, 255)), 1'b1);
      else begin
        // literal cut off by a restart
        send_literal($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE, rand_value_len(), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_symbols_numbers();
    test_brackets_unknown();
    test_literals();
    test_restart();
    test_long_values();
    test_random_text();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/stt_pkg.sv
src/stt_cmd_fifo.sv
src/stt_front.sv
src/stt_back.sv
src/source_text_tokenizer_unit.sv
test/tb.sv
